@@ src/mcac_pkg.sv @@
// Package for the magnetometer cross-axis compensation block.
// Holds command and status codes and the sequencer state type; no dependencies.
package mcac_pkg;

    localparam logic CMD_COMPUTE    = 1'b0;
    localparam logic CMD_COMPENSATE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SINGULAR = 2'd1,
        STATUS_UNCAL    = 2'd2
    } status_t;

    localparam logic [1:0] REG_ROW_0 = 2'd0;
    localparam logic [1:0] REG_ROW_1 = 2'd1;
    localparam logic [1:0] REG_ROW_2 = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COF,     // one adjugate product per step, accumulated
        ST_DET,     // determinant terms
        ST_DOT,     // adj row times sample
        ST_SCALE,   // numerator times 100
        ST_RANGE,   // early saturation check against the shifted divisor
        ST_DIVIDE,  // restoring division, one bit per step
        ST_STORE,   // saturate and store one field
        ST_OUT      // hold result word
    } state_t;

endpackage

@@ src/magnetometer_cross_axis_compensation_top.sv @@
// Magnetometer cross-axis compensation top level; uses mcac_pkg, one shared 33x33 multiplier.
// Compute: each adjugate entry is accumulated, then the determinant terms, then a store;
// calibrated sample: per axis a dot product, scaling, a range check and the divider
// (one quotient bit a cycle; an axis found to saturate skips it); uncalibrated goes straight out.
// Throughput: one item at a time; s_tready is high only while idle.
// aresetn (synchronous, active low) clears calibration, adjugate, determinant and flag.
module magnetometer_cross_axis_compensation_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // raw_x, raw_y, raw_z
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // field_x, field_y, field_z
    output logic [1:0]  m_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import mcac_pkg::*;

    // The remainder holds |num * 100| << FRAC_BITS and the divisor shifted up by 32.
    localparam int NW = 55 + FRAC_BITS;
    localparam int RW = (NW > 82) ? NW : 82;

    logic [47:0]        cal_reg [3];
    logic signed [15:0] w [9];
    logic signed [32:0] adj_reg [9];
    logic signed [32:0] nadj_reg [9];
    logic signed [49:0] det_reg, det_next;
    logic signed [49:0] ndet_reg, ndet_next;
    logic               calib_reg, calib_next;

    state_t             state_reg, state_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [1:0]         row_reg, row_next;
    logic [1:0]         term_reg, term_next;
    logic               cmd_reg, cmd_next;
    logic signed [15:0] vin_reg [3];
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] prod_reg;
    logic               sub_reg;
    logic [RW-1:0]      rem_reg, rem_next;
    logic [RW-1:0]      dsh_reg, dsh_next;
    logic [49:0]        den_reg, den_next;
    logic [31:0]        quo_reg, quo_next;
    logic               neg_reg, neg_next;
    logic               ovf_reg, ovf_next;
    logic [31:0]        fld_reg [3];
    status_t            stat_reg, stat_next;

    logic [3:0]         ia, ib;
    logic [3:0]         adj_idx, det_idx;
    logic signed [32:0] op_a, op_b;
    logic               sub_term;
    logic signed [65:0] prod_full;
    logic signed [63:0] acc_sum;
    logic [49:0]        det_mag;
    logic [63:0]        acc_mag, num_mag;
    logic [RW-1:0]      den_top;
    logic [RW:0]        diff;
    logic [31:0]        sat_val;

    assign cfg_ready = (state_reg != ST_COF) && (state_reg != ST_DET);
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = {fld_reg[2], fld_reg[1], fld_reg[0]};
    assign m_tuser   = stat_reg;

    assign w[0] = cal_reg[0][15:0];
    assign w[1] = cal_reg[0][31:16];
    assign w[2] = cal_reg[0][47:32];
    assign w[3] = cal_reg[1][15:0];
    assign w[4] = cal_reg[1][31:16];
    assign w[5] = cal_reg[1][47:32];
    assign w[6] = cal_reg[2][15:0];
    assign w[7] = cal_reg[2][31:16];
    assign w[8] = cal_reg[2][47:32];

    // Matrix words for adjugate entry cnt: term 0 is added, term 1 subtracted.
    always_comb begin
        ia = 4'd0;
        ib = 4'd0;
        unique case (cnt_reg[3:0])
            4'd0: begin ia = term_reg[0] ? 4'd5 : 4'd4; ib = term_reg[0] ? 4'd7 : 4'd8; end
            4'd1: begin ia = term_reg[0] ? 4'd1 : 4'd2; ib = term_reg[0] ? 4'd8 : 4'd7; end
            4'd2: begin ia = term_reg[0] ? 4'd2 : 4'd1; ib = term_reg[0] ? 4'd4 : 4'd5; end
            4'd3: begin ia = term_reg[0] ? 4'd3 : 4'd5; ib = term_reg[0] ? 4'd8 : 4'd6; end
            4'd4: begin ia = term_reg[0] ? 4'd2 : 4'd0; ib = term_reg[0] ? 4'd6 : 4'd8; end
            4'd5: begin ia = term_reg[0] ? 4'd0 : 4'd2; ib = term_reg[0] ? 4'd5 : 4'd3; end
            4'd6: begin ia = term_reg[0] ? 4'd4 : 4'd3; ib = term_reg[0] ? 4'd6 : 4'd7; end
            4'd7: begin ia = term_reg[0] ? 4'd0 : 4'd1; ib = term_reg[0] ? 4'd7 : 4'd6; end
            default: begin ia = term_reg[0] ? 4'd1 : 4'd0; ib = term_reg[0] ? 4'd3 : 4'd4; end
        endcase
    end

    assign adj_idx = {2'b00, row_reg} * 4'd3 + {2'b00, term_reg};
    assign det_idx = {2'b00, term_reg} * 4'd3;

    // Operand selection for the shared multiplier; the last step of each pass only drains.
    always_comb begin
        op_a = '0;
        op_b = '0;
        sub_term = 1'b0;
        unique case (state_reg)
            ST_COF: begin
                if (term_reg != 2'd2) begin
                    op_a = 33'(w[ia]);
                    op_b = 33'(w[ib]);
                    sub_term = term_reg[0];
                end
            end
            ST_DET: begin
                if (term_reg != 2'd3) begin
                    op_a = 33'(w[{2'b00, term_reg}]);
                    op_b = nadj_reg[det_idx];
                end
            end
            ST_DOT: begin
                if (term_reg != 2'd3) begin
                    op_a = adj_reg[adj_idx];
                    op_b = 33'(vin_reg[term_reg]);
                end
            end
            default: ;
        endcase
    end

    assign prod_full = op_a * op_b;
    assign acc_sum   = sub_reg ? acc_reg - prod_reg : acc_reg + prod_reg;
    assign det_mag   = det_reg[49] ? -det_reg : det_reg;
    assign acc_mag   = acc_reg[63] ? -acc_reg : acc_reg;
    assign num_mag   = (acc_mag << 6) + (acc_mag << 5) + (acc_mag << 2);
    assign den_top   = RW'(den_reg) << 32;
    assign diff      = {1'b0, rem_reg} - {1'b0, dsh_reg};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        row_next   = row_reg;
        term_next  = term_reg;
        cmd_next   = cmd_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        stat_next  = stat_reg;
        calib_next = calib_reg;
        det_next   = det_reg;
        ndet_next  = ndet_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next  = s_tuser;
                    row_next  = '0;
                    term_next = '0;
                    cnt_next  = '0;
                    acc_next  = '0;
                    den_next  = (det_mag << 1) + det_mag;
                    priority if (s_tuser == CMD_COMPUTE) begin
                        state_next = ST_COF;
                    end else if (!calib_reg || det_reg == '0) begin
                        stat_next  = STATUS_UNCAL;
                        state_next = ST_OUT;
                    end else begin
                        stat_next  = STATUS_OK;
                        state_next = ST_DOT;
                    end
                end
            end
            ST_COF: begin
                if (term_reg == 2'd2) begin
                    term_next = '0;
                    acc_next  = '0;
                    if (cnt_reg == 5'd8) begin
                        state_next = ST_DET;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + 5'd1;
                    end
                end else begin
                    term_next = term_reg + 2'd1;
                    acc_next  = (term_reg == 2'd0) ? '0 : acc_sum;
                end
            end
            ST_DET: begin
                if (term_reg == 2'd3) begin
                    ndet_next  = 50'(acc_sum);
                    term_next  = '0;
                    acc_next   = '0;
                    state_next = ST_STORE;
                end else begin
                    term_next = term_reg + 2'd1;
                    acc_next  = (term_reg == 2'd0) ? '0 : acc_sum;
                end
            end
            ST_DOT: begin
                if (term_reg == 2'd3) begin
                    acc_next   = acc_sum;
                    term_next  = '0;
                    state_next = ST_SCALE;
                end else begin
                    term_next = term_reg + 2'd1;
                    acc_next  = (term_reg == 2'd0) ? '0 : acc_sum;
                end
            end
            ST_SCALE: begin
                rem_next   = RW'(num_mag) << FRAC_BITS;
                neg_next   = acc_reg[63] ^ det_reg[49];
                state_next = ST_RANGE;
            end
            ST_RANGE: begin
                // A quotient of 2^32 or more saturates either way, so skip the divider.
                ovf_next   = (rem_reg >= den_top);
                dsh_next   = den_top >> 1;
                quo_next   = '0;
                cnt_next   = '0;
                state_next = (rem_reg >= den_top) ? ST_STORE : ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (!diff[RW]) rem_next = diff[RW-1:0];
                quo_next = {quo_reg[30:0], !diff[RW]};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) state_next = ST_STORE;
            end
            ST_STORE: begin
                if (cmd_reg == CMD_COMPENSATE) begin
                    if (row_reg != 2'd2) begin
                        row_next   = row_reg + 2'd1;
                        term_next  = '0;
                        acc_next   = '0;
                        state_next = ST_DOT;
                    end else begin
                        state_next = ST_OUT;
                    end
                end else begin
                    if (ndet_reg == '0) begin
                        stat_next  = STATUS_SINGULAR;
                        calib_next = 1'b0;
                    end else begin
                        stat_next  = STATUS_OK;
                        calib_next = 1'b1;
                        det_next   = ndet_reg;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT: if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        priority if (ovf_reg) begin
            sat_val = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (!neg_reg) begin
            sat_val = quo_reg[31] ? 32'h7FFF_FFFF : quo_reg;
        end else begin
            sat_val = (quo_reg > 32'h8000_0000) ? 32'h8000_0000 : -quo_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            row_reg   <= '0;
            term_reg  <= '0;
            cmd_reg   <= CMD_COMPUTE;
            acc_reg   <= '0;
            prod_reg  <= '0;
            sub_reg   <= 1'b0;
            rem_reg   <= '0;
            dsh_reg   <= '0;
            den_reg   <= '0;
            quo_reg   <= '0;
            neg_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            stat_reg  <= STATUS_OK;
            calib_reg <= 1'b0;
            det_reg   <= '0;
            ndet_reg  <= '0;
            for (int i = 0; i < 3; i++) begin
                cal_reg[i] <= '0;
                vin_reg[i] <= '0;
                fld_reg[i] <= '0;
            end
            for (int i = 0; i < 9; i++) begin
                adj_reg[i]  <= '0;
                nadj_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            term_reg  <= term_next;
            cmd_reg   <= cmd_next;
            acc_reg   <= acc_next;
            prod_reg  <= prod_full[63:0];
            sub_reg   <= sub_term;
            rem_reg   <= rem_next;
            dsh_reg   <= dsh_next;
            den_reg   <= den_next;
            quo_reg   <= quo_next;
            neg_reg   <= neg_next;
            ovf_reg   <= ovf_next;
            stat_reg  <= stat_next;
            calib_reg <= calib_next;
            det_reg   <= det_next;
            ndet_reg  <= ndet_next;
            if (cfg_valid && cfg_ready && cfg_index <= REG_ROW_2)
                cal_reg[cfg_index] <= cfg_data;
            if (state_reg == ST_COF && term_reg == 2'd2)
                nadj_reg[cnt_reg[3:0]] <= 33'(acc_sum);
            if (state_reg == ST_IDLE && s_tvalid) begin
                for (int i = 0; i < 3; i++) begin
                    vin_reg[i] <= s_tdata[16 * i +: 16];
                    fld_reg[i] <= '0;
                end
            end else if (state_reg == ST_STORE && cmd_reg == CMD_COMPENSATE) begin
                fld_reg[row_reg] <= sat_val;
            end
            if (state_reg == ST_STORE && cmd_reg == CMD_COMPUTE && ndet_reg != '0) begin
                for (int i = 0; i < 9; i++) adj_reg[i] <= nadj_reg[i];
            end
        end
    end

endmodule
